@@ rtl/bofg_pkg.sv @@
// shared constants, register indexes and types of the battery overvoltage flip guard
package bofg_pkg;

    localparam int TIME_BITS      = 32;
    localparam int VOLT_FRAC_BITS = 16;
    localparam int SAMPLE_W       = 16;
    localparam int NOW_W          = 32;
    localparam int VOLT_W         = SAMPLE_W + VOLT_FRAC_BITS;
    localparam int ALPHA_W        = 17;
    localparam int THR_W          = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [ALPHA_W-1:0] ONE_Q16  = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] HALF_Q16 = ALPHA_W'(32768);

    localparam logic [THR_W-1:0] RAMP_START    = THR_W'(500);
    localparam logic [THR_W-1:0] RAMP_STEP     = THR_W'(50);
    localparam logic [THR_W-1:0] THROTTLE_FULL = THR_W'(1500);

    localparam logic [TIME_BITS-1:0] PULSE_ON_MS     = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0] PULSE_PERIOD_MS = TIME_BITS'(2000);

    localparam logic [VOLT_W-1:0] WINDOW_RESET_LEVEL = VOLT_W'(64'd500 << VOLT_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_ALPHA     = 3'd0,
        CFG_FLIP_THR      = 3'd1,
        CFG_PANIC_THR     = 3'd2,
        CFG_STARTUP_DELAY = 3'd3,
        CFG_WINDOW        = 3'd4,
        CFG_PANIC_AFTER   = 3'd5,
        CFG_RECOVER_AFTER = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [16:0] ema_alpha_q16;
        logic [15:0] flip_threshold;
        logic [15:0] panic_threshold;
        logic [15:0] startup_delay_ms;
        logic [19:0] window_ms;
        logic [23:0] panic_after_ms;
        logic [15:0] recover_after_ms;
    } t_cfg;

    typedef struct packed {
        logic [NOW_W-1:0]    now_ms;
        logic [SAMPLE_W-1:0] voltage_sample;
        logic                upside_down;
    } t_item;

    typedef struct packed {
        logic             override_active;
        logic [THR_W-1:0] drive_throttle;
        logic             reverse_command;
        logic             normal_command;
        logic             back_reversed;
        logic             flip_active;
        logic             panic_active;
        logic             unsafe_voltage;
    } t_result;

endpackage

@@ rtl/bofg_cfg_if.sv @@
// configuration write channel
interface bofg_cfg_if import bofg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bofg_in_if.sv @@
// input sample channel
interface bofg_in_if import bofg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NOW_W-1:0]    now_ms;
    logic [SAMPLE_W-1:0] voltage_sample;
    logic                upside_down;

    modport source (output valid, output now_ms, output voltage_sample, output upside_down,
                    input ready);
    modport sink   (input valid, input now_ms, input voltage_sample, input upside_down,
                    output ready);
endinterface

@@ rtl/bofg_out_if.sv @@
// result channel
interface bofg_out_if import bofg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             override_active;
    logic [THR_W-1:0] drive_throttle;
    logic             reverse_command;
    logic             normal_command;
    logic             back_reversed;
    logic             flip_active;
    logic             panic_active;
    logic             unsafe_voltage;

    modport source (output valid, output override_active, output drive_throttle,
                    output reverse_command, output normal_command, output back_reversed,
                    output flip_active, output panic_active, output unsafe_voltage,
                    input ready);
    modport sink   (input valid, input override_active, input drive_throttle,
                    input reverse_command, input normal_command, input back_reversed,
                    input flip_active, input panic_active, input unsafe_voltage,
                    output ready);
endinterface

@@ rtl/bofg_cfg_regs.sv @@
// configuration register file
module bofg_cfg_regs import bofg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bofg_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_EMA_ALPHA:     n_cfg.ema_alpha_q16    = i_cfg.data[16:0];
                CFG_FLIP_THR:      n_cfg.flip_threshold   = i_cfg.data[15:0];
                CFG_PANIC_THR:     n_cfg.panic_threshold  = i_cfg.data[15:0];
                CFG_STARTUP_DELAY: n_cfg.startup_delay_ms = i_cfg.data[15:0];
                CFG_WINDOW:        n_cfg.window_ms        = i_cfg.data[19:0];
                CFG_PANIC_AFTER:   n_cfg.panic_after_ms   = i_cfg.data[23:0];
                CFG_RECOVER_AFTER: n_cfg.recover_after_ms = i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_alpha_q16    <= 17'd655;
            r_cfg.flip_threshold   <= 16'd435;
            r_cfg.panic_threshold  <= 16'd480;
            r_cfg.startup_delay_ms <= 16'd10000;
            r_cfg.window_ms        <= 20'd72000;
            r_cfg.panic_after_ms   <= 24'd300000;
            r_cfg.recover_after_ms <= 16'd15000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/bofg_update.sv @@
// guard state and its single-pass update for one sample
module bofg_update import bofg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_step,
    output t_result o_result
);

    localparam int PNEW_W = ALPHA_W + SAMPLE_W;
    localparam int POLD_W = ALPHA_W + VOLT_W;
    localparam int ACC_W  = POLD_W + 1;

    logic [VOLT_W-1:0]    r_smoothed, n_smoothed;
    logic [VOLT_W-1:0]    r_win_low, n_win_low;
    logic [VOLT_W-1:0]    r_prev_low, n_prev_low;
    logic [TIME_BITS-1:0] r_win_start, n_win_start;
    logic [TIME_BITS-1:0] r_safe_t, n_safe_t;
    logic [TIME_BITS-1:0] r_unsafe_t, n_unsafe_t;
    logic                 r_flip, n_flip;
    logic                 r_panic, n_panic;
    logic                 r_rev, n_rev;
    logic                 r_ramp_on, n_ramp_on;
    logic [THR_W-1:0]     r_ramp_thr, n_ramp_thr;
    logic [TIME_BITS-1:0] r_ramp_t, n_ramp_t;

    logic [TIME_BITS-1:0] now_t;
    logic                 past_startup;
    logic [ALPHA_W-1:0]   alpha_c;
    logic [PNEW_W-1:0]    p_new;
    logic [POLD_W-1:0]    p_old;
    logic [ACC_W-1:0]     acc;
    logic [VOLT_W-1:0]    ema;
    logic [VOLT_W-1:0]    low_upd;
    logic [TIME_BITS-1:0] d_win, d_safe, d_unsafe, d_ramp;
    logic                 recover;
    logic [THR_W-1:0]     ramp_next;

    assign now_t        = TIME_BITS'(i_item.now_ms);
    assign past_startup = 64'(now_t) >= 64'(i_cfg.startup_delay_ms);
    assign alpha_c      = (i_cfg.ema_alpha_q16 > ONE_Q16) ? ONE_Q16 : i_cfg.ema_alpha_q16;

    // rounded exponential average: alpha*v + (1-alpha)*s, half up
    assign p_new = PNEW_W'(alpha_c) * PNEW_W'(i_item.voltage_sample);
    assign p_old = POLD_W'(ONE_Q16 - alpha_c) * POLD_W'(r_smoothed);
    assign acc   = (ACC_W'(p_new) << VOLT_FRAC_BITS) + ACC_W'(p_old) + ACC_W'(HALF_Q16);
    assign ema   = VOLT_W'(acc >> 16);

    assign low_upd = (ema < r_win_low) ? ema : r_win_low;
    assign d_win   = now_t - r_win_start;

    always_comb begin
        n_smoothed  = r_smoothed;
        n_win_low   = r_win_low;
        n_prev_low  = r_prev_low;
        n_win_start = r_win_start;
        n_safe_t    = r_safe_t;
        n_unsafe_t  = r_unsafe_t;
        n_flip      = r_flip;
        n_panic     = r_panic;
        n_rev       = r_rev;
        n_ramp_on   = r_ramp_on;
        n_ramp_thr  = r_ramp_thr;
        n_ramp_t    = r_ramp_t;
        d_safe      = '0;
        d_unsafe    = '0;
        d_ramp      = '0;
        recover     = 1'b0;
        ramp_next   = '0;
        o_result    = '0;

        if (past_startup) begin
            n_smoothed = ema;
            n_win_low  = low_upd;
            if (64'(d_win) > 64'(i_cfg.window_ms)) begin
                n_win_start = now_t;
                n_prev_low  = low_upd;
                n_win_low   = WINDOW_RESET_LEVEL;
            end

            if (n_prev_low < (VOLT_W'(i_cfg.flip_threshold) << VOLT_FRAC_BITS)) begin
                n_safe_t = now_t;
            end else begin
                n_flip     = 1'b1;
                n_unsafe_t = now_t;
            end

            d_safe = now_t - n_safe_t;
            if (ema > (VOLT_W'(i_cfg.panic_threshold) << VOLT_FRAC_BITS) ||
                64'(d_safe) > 64'(i_cfg.panic_after_ms)) begin
                n_panic = 1'b1;
            end

            d_unsafe = now_t - n_unsafe_t;
            recover  = ((n_panic || n_flip) && 64'(d_unsafe) > 64'(i_cfg.recover_after_ms)) ||
                       (!n_panic && n_flip && i_item.upside_down);

            if (recover) begin
                o_result.override_active = 1'b1;
                n_ramp_on = 1'b0;
                if (r_rev) begin
                    o_result.normal_command = 1'b1;
                    n_rev = 1'b0;
                end
                n_panic = 1'b0;
                n_flip  = 1'b0;
            end else if (n_panic || n_flip) begin
                if (n_panic) begin
                    o_result.drive_throttle = THROTTLE_FULL;
                end else begin
                    // fresh ramp starts at the base level with its clock at now
                    if (!r_ramp_on) begin
                        n_ramp_thr = RAMP_START;
                        n_ramp_t   = now_t;
                        n_ramp_on  = 1'b1;
                    end
                    d_ramp    = now_t - n_ramp_t;
                    ramp_next = n_ramp_thr + RAMP_STEP;
                    if (d_ramp < PULSE_ON_MS) begin
                        o_result.drive_throttle = n_ramp_thr;
                    end else if (d_ramp < PULSE_PERIOD_MS) begin
                        o_result.drive_throttle = '0;
                    end else begin
                        if (ramp_next > THROTTLE_FULL) begin
                            ramp_next = THROTTLE_FULL;
                        end
                        n_ramp_thr = ramp_next;
                        n_ramp_t   = now_t;
                        o_result.drive_throttle = ramp_next;
                    end
                end
                if (!r_rev) begin
                    o_result.reverse_command = 1'b1;
                    n_rev = 1'b1;
                end
                o_result.override_active = 1'b1;
            end
        end

        o_result.back_reversed  = n_rev;
        o_result.flip_active    = n_flip;
        o_result.panic_active   = n_panic;
        o_result.unsafe_voltage = n_flip || n_panic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed  <= '0;
            r_win_low   <= WINDOW_RESET_LEVEL;
            r_prev_low  <= '0;
            r_win_start <= '0;
            r_safe_t    <= '0;
            r_unsafe_t  <= '0;
            r_flip      <= 1'b0;
            r_panic     <= 1'b0;
            r_rev       <= 1'b0;
            r_ramp_on   <= 1'b0;
            r_ramp_thr  <= RAMP_START;
            r_ramp_t    <= '0;
        end else if (i_step) begin
            r_smoothed  <= n_smoothed;
            r_win_low   <= n_win_low;
            r_prev_low  <= n_prev_low;
            r_win_start <= n_win_start;
            r_safe_t    <= n_safe_t;
            r_unsafe_t  <= n_unsafe_t;
            r_flip      <= n_flip;
            r_panic     <= n_panic;
            r_rev       <= n_rev;
            r_ramp_on   <= n_ramp_on;
            r_ramp_thr  <= n_ramp_thr;
            r_ramp_t    <= n_ramp_t;
        end
    end

endmodule

@@ rtl/battery_overvoltage_flip_guard.sv @@
// Battery overvoltage flip guard. Takes one sample beat per clock unless the result
// side stalls, and returns one result beat per sample, in order. A sample is captured
// in an input register; as it moves on, the guard state (voltage average, window
// minimum, mode flags, flip ramp) is updated and the result lands in an output
// register, from which it is offered and taken when the result side is ready.
// Sustained rate is one sample per cycle while the result side is ready; the per-cycle
// path is the 17 x 32 bit averaging multiply feeding the window, panic and ramp
// compares, since each sample depends on the state left by the one before.
// Configuration writes are taken at any time but are meant for when the block is idle.
module battery_overvoltage_flip_guard import bofg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bofg_cfg_if.sink    i_cfg,
    bofg_in_if.sink     i_item,
    bofg_out_if.source  o_result
);

    t_cfg    cfg;
    t_result result;
    logic    advance;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    bofg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bofg_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_step   (advance),
        .o_result (result)
    );

    // held sample moves on when the output register is free or being drained
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.now_ms         <= i_item.now_ms;
            r_in.voltage_sample <= i_item.voltage_sample;
            r_in.upside_down    <= i_item.upside_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.override_active = r_out.override_active;
    assign o_result.drive_throttle  = r_out.drive_throttle;
    assign o_result.reverse_command = r_out.reverse_command;
    assign o_result.normal_command  = r_out.normal_command;
    assign o_result.back_reversed   = r_out.back_reversed;
    assign o_result.flip_active     = r_out.flip_active;
    assign o_result.panic_active    = r_out.panic_active;
    assign o_result.unsafe_voltage  = r_out.unsafe_voltage;

endmodule

@@ verif/bofg_check.sv @@
// scoreboard for the flip guard: watches the channels, predicts every result beat and compares
`timescale 1ns / 1ps
module bofg_check import bofg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bofg_cfg_if  i_cfg,
    bofg_in_if   i_item,
    bofg_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);

    // guard registers as last written
    t_cfg guard_cfg;

    // guard state
    logic [31:0]      avg_volt;
    logic [31:0]      win_min;
    logic [31:0]      held_min;
    logic [31:0]      win_start;
    logic [31:0]      safe_at;
    logic [31:0]      unsafe_at;
    logic             flip_on;
    logic             panic_on;
    logic             back_rev;
    logic             ramp_on;
    logic [THR_W-1:0] ramp_level;
    logic [31:0]      ramp_at;

    t_result motor_cmd_q[$];
    int      fails;

    task automatic clear_guard();
        guard_cfg.ema_alpha_q16    = 17'd655;
        guard_cfg.flip_threshold   = 16'd435;
        guard_cfg.panic_threshold  = 16'd480;
        guard_cfg.startup_delay_ms = 16'd10000;
        guard_cfg.window_ms        = 20'd72000;
        guard_cfg.panic_after_ms   = 24'd300000;
        guard_cfg.recover_after_ms = 16'd15000;
        avg_volt   = '0;
        win_min    = WINDOW_RESET_LEVEL;
        held_min   = '0;
        win_start  = '0;
        safe_at    = '0;
        unsafe_at  = '0;
        flip_on    = 1'b0;
        panic_on   = 1'b0;
        back_rev   = 1'b0;
        ramp_on    = 1'b0;
        ramp_level = RAMP_START;
        ramp_at    = '0;
    endtask

    task automatic write_guard_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_EMA_ALPHA:     guard_cfg.ema_alpha_q16    = data[16:0];
            CFG_FLIP_THR:      guard_cfg.flip_threshold   = data[15:0];
            CFG_PANIC_THR:     guard_cfg.panic_threshold  = data[15:0];
            CFG_STARTUP_DELAY: guard_cfg.startup_delay_ms = data[15:0];
            CFG_WINDOW:        guard_cfg.window_ms        = data[19:0];
            CFG_PANIC_AFTER:   guard_cfg.panic_after_ms   = data[23:0];
            CFG_RECOVER_AFTER: guard_cfg.recover_after_ms = data[15:0];
            default: ;
        endcase
    endtask

    function automatic t_result guard_step(t_item it);
        t_result     r;
        logic [16:0] wt;
        logic [63:0] acc;
        logic [31:0] now;
        logic [31:0] gap;
        logic        recover;
        r   = '0;
        now = it.now_ms;
        if (now >= 32'(guard_cfg.startup_delay_ms)) begin
            wt  = (guard_cfg.ema_alpha_q16 > ONE_Q16) ? ONE_Q16 : guard_cfg.ema_alpha_q16;
            acc = 64'(wt) * 64'({it.voltage_sample, {VOLT_FRAC_BITS{1'b0}}})
                + 64'(ONE_Q16 - wt) * 64'(avg_volt) + 64'(HALF_Q16);
            avg_volt = acc[47:16];

            if (avg_volt < win_min)
                win_min = avg_volt;
            gap = now - win_start;
            if (gap > 32'(guard_cfg.window_ms)) begin
                win_start = now;
                held_min  = win_min;
                win_min   = WINDOW_RESET_LEVEL;
            end

            if (held_min < {guard_cfg.flip_threshold, {VOLT_FRAC_BITS{1'b0}}}) begin
                safe_at = now;
            end else begin
                flip_on   = 1'b1;
                unsafe_at = now;
            end

            gap = now - safe_at;
            if (avg_volt > {guard_cfg.panic_threshold, {VOLT_FRAC_BITS{1'b0}}} ||
                gap > 32'(guard_cfg.panic_after_ms))
                panic_on = 1'b1;

            gap     = now - unsafe_at;
            recover = (panic_on || flip_on) && gap > 32'(guard_cfg.recover_after_ms);
            // inverted while only flipping stops the motors as well
            if (!recover && !panic_on && flip_on && it.upside_down)
                recover = 1'b1;

            if (recover) begin
                r.override_active = 1'b1;
                ramp_on           = 1'b0;
                if (back_rev) begin
                    r.normal_command = 1'b1;
                    back_rev         = 1'b0;
                end
                panic_on = 1'b0;
                flip_on  = 1'b0;
            end else if (panic_on || flip_on) begin
                if (panic_on) begin
                    r.drive_throttle = THROTTLE_FULL;
                end else begin
                    if (!ramp_on) begin
                        ramp_level = RAMP_START;
                        ramp_at    = now;
                        ramp_on    = 1'b1;
                    end
                    gap = now - ramp_at;
                    if (gap < PULSE_ON_MS) begin
                        r.drive_throttle = ramp_level;
                    end else if (gap < PULSE_PERIOD_MS) begin
                        r.drive_throttle = '0;
                    end else begin
                        ramp_level = (ramp_level + RAMP_STEP > THROTTLE_FULL) ?
                                     THROTTLE_FULL : ramp_level + RAMP_STEP;
                        ramp_at          = now;
                        r.drive_throttle = ramp_level;
                    end
                end
                if (!back_rev) begin
                    r.reverse_command = 1'b1;
                    back_rev          = 1'b1;
                end
                r.override_active = 1'b1;
            end
        end
        r.back_reversed  = back_rev;
        r.flip_active    = flip_on;
        r.panic_active   = panic_on;
        r.unsafe_voltage = flip_on | panic_on;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= 50)
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_guard();
            motor_cmd_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                write_guard_reg(t_cfg_idx'(i_cfg.index), i_cfg.data);
            if (i_item.valid && i_item.ready) begin
                it.now_ms         = i_item.now_ms;
                it.voltage_sample = i_item.voltage_sample;
                it.upside_down    = i_item.upside_down;
                motor_cmd_q.push_back(guard_step(it));
            end
            if (i_result.valid && i_result.ready) begin
                got.override_active = i_result.override_active;
                got.drive_throttle  = i_result.drive_throttle;
                got.reverse_command = i_result.reverse_command;
                got.normal_command  = i_result.normal_command;
                got.back_reversed   = i_result.back_reversed;
                got.flip_active     = i_result.flip_active;
                got.panic_active    = i_result.panic_active;
                got.unsafe_voltage  = i_result.unsafe_voltage;
                if (motor_cmd_q.size() == 0) begin
                    fails++;
                    if (fails <= 50)
                        $display("%0t result beat with nothing pending: expected none, actual %h",
                                 $time, got);
                end else begin
                    want = motor_cmd_q.pop_front();
                    check_field("override_active", want.override_active, got.override_active);
                    check_field("drive_throttle", want.drive_throttle, got.drive_throttle);
                    check_field("reverse_command", want.reverse_command, got.reverse_command);
                    check_field("normal_command", want.normal_command, got.normal_command);
                    check_field("back_reversed", want.back_reversed, got.back_reversed);
                    check_field("flip_active", want.flip_active, got.flip_active);
                    check_field("panic_active", want.panic_active, got.panic_active);
                    check_field("unsafe_voltage", want.unsafe_voltage, got.unsafe_voltage);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= motor_cmd_q.size();
    end

endmodule

@@ verif/tb_battery_overvoltage_flip_guard.sv @@
// stimulus, handshake pacing and verdict for the battery overvoltage flip guard
`timescale 1ns / 1ps
module tb_battery_overvoltage_flip_guard;
    import bofg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bofg_cfg_if cfg_bus();
    bofg_in_if  item_bus();
    bofg_out_if result_bus();

    int          fail_cnt;
    int          pending_cnt;
    int          cycle_cnt = 0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        long_hold_req;
    logic [31:0] clock_ms;

    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    battery_overvoltage_flip_guard dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    bofg_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_item       (item_bus),
        .i_result     (result_bus),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side pacing: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    task automatic program_guard(int alpha, int flip_thr, int panic_thr, int startup,
                                 int window, int panic_after, int recover);
        write_reg(CFG_EMA_ALPHA, CFG_DATA_W'(alpha));
        write_reg(CFG_FLIP_THR, CFG_DATA_W'(flip_thr));
        write_reg(CFG_PANIC_THR, CFG_DATA_W'(panic_thr));
        write_reg(CFG_STARTUP_DELAY, CFG_DATA_W'(startup));
        write_reg(CFG_WINDOW, CFG_DATA_W'(window));
        write_reg(CFG_PANIC_AFTER, CFG_DATA_W'(panic_after));
        write_reg(CFG_RECOVER_AFTER, CFG_DATA_W'(recover));
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] now, logic [15:0] volt, logic inverted);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.now_ms         <= now;
        item_bus.voltage_sample <= volt;
        item_bus.upside_down    <= inverted;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    // stop offering and wait until every predicted beat has come back
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    // one setting per flavor; also places the time cursor
    task automatic setup_flavor(int flavor);
        case (flavor)
            0: begin
                program_guard($urandom_range(8000, 65536), $urandom_range(430, 450),
                              $urandom_range(470, 490), $urandom_range(0, 3000),
                              $urandom_range(0, 3000), $urandom_range(2000, 30000),
                              $urandom_range(500, 8000));
                clock_ms = '0;
            end
            1: begin
                // long flip: panic out of reach, slow recovery, ramp runs to saturation
                program_guard(65536, 440, 65535, 0, $urandom_range(0, 500), 16777215, 65535);
                clock_ms = $urandom();
            end
            2: begin
                program_guard(0, 0, 0, 0, 0, 0, 0);
                clock_ms = 32'hFFFF_F000;
            end
            3: begin
                program_guard(131071, 65535, 65535, 65535, 1048575, 16777215, 65535);
                clock_ms = '0;
            end
            default: begin
                program_guard($urandom_range(0, 131071), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1048575), $urandom_range(0, 16777215),
                              $urandom_range(0, 65535));
                clock_ms = $urandom();
            end
        endcase
    endtask

    task automatic run_samples(int count, int flavor, int hold_at, int pause_at);
        int          step_lo;
        int          step_hi;
        int          v_lo;
        int          v_hi;
        int          inv_pct;
        int          jump_pct;
        int          roll;
        logic [15:0] volt;
        case (flavor)
            0:       begin step_lo = 1;   step_hi = 600;    v_lo = 400;   v_hi = 500;
                           inv_pct = 8;  jump_pct = 2; end
            1:       begin step_lo = 400; step_hi = 900;    v_lo = 445;   v_hi = 470;
                           inv_pct = 0;  jump_pct = 0; end
            2:       begin step_lo = 0;   step_hi = 3;      v_lo = 0;     v_hi = 20;
                           inv_pct = 20; jump_pct = 2; end
            3:       begin step_lo = 1;   step_hi = 20000;  v_lo = 60000; v_hi = 65535;
                           inv_pct = 30; jump_pct = 2; end
            default: begin step_lo = 0;   step_hi = 100000; v_lo = 0;     v_hi = 65535;
                           inv_pct = 50; jump_pct = 5; end
        endcase
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                long_hold_req <= 1'b1;
            if (k == pause_at)
                wait_drained();
            if ($urandom_range(0, 99) < jump_pct)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + 32'($urandom_range(step_lo, step_hi));
            roll = $urandom_range(0, 99);
            if (roll < 3)
                volt = (roll == 1) ? 16'hFFFF : 16'h0000;
            else if (roll < 12)
                volt = 16'($urandom());
            else
                volt = 16'($urandom_range(v_lo, v_hi));
            send_sample(clock_ms, volt, $urandom_range(0, 99) < inv_pct);
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= CFG_EMA_ALPHA;
        cfg_bus.data            <= '0;
        item_bus.valid          <= 1'b0;
        item_bus.now_ms         <= '0;
        item_bus.voltage_sample <= '0;
        item_bus.upside_down    <= 1'b0;
        long_hold_req           <= 1'b0;
        rx_idle_pct             <= 0;
        tx_idle_pct = 0;
        clock_ms    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: startup window, panic on a high average, recovery, window end, wrap
        send_sample(32'd0, 16'd0, 1'b0);
        send_sample(32'd9999, 16'hFFFF, 1'b1);
        send_sample(32'd10000, 16'hFFFF, 1'b0);
        send_sample(32'd10500, 16'd0, 1'b1);
        send_sample(32'd25001, 16'd0, 1'b0);
        send_sample(32'd25002, 16'hFFFF, 1'b0);
        send_sample(32'd72001, 16'hFFFF, 1'b0);
        send_sample(32'd72002, 16'd0, 1'b1);
        send_sample(32'hFFFF_FFFF, 16'd0, 1'b1);
        wait_drained();

        // flip ramp: pulse, pause, step up, then inverted stops the motors
        program_guard(65536, 435, 480, 0, 0, 16777215, 5000);
        send_sample(32'd1000, 16'd450, 1'b0);
        send_sample(32'd1500, 16'd450, 1'b0);
        send_sample(32'd2500, 16'd450, 1'b0);
        send_sample(32'd3000, 16'd450, 1'b0);
        send_sample(32'd3100, 16'd450, 1'b1);
        send_sample(32'd3200, 16'd460, 1'b0);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            setup_flavor(p % 5);
            tx_idle_pct = (p == 9) ? 0 : pick_idle_pct();
            rx_idle_pct <= (p == 9) ? 0 : pick_idle_pct();
            run_samples(85, p % 5, (p == 2) ? 20 : -1, (p == 4) ? 40 : -1);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ battery_overvoltage_flip_guard.f @@
rtl/bofg_pkg.sv
rtl/bofg_cfg_if.sv
rtl/bofg_in_if.sv
rtl/bofg_out_if.sv
rtl/bofg_cfg_regs.sv
rtl/bofg_update.sv
rtl/battery_overvoltage_flip_guard.sv
verif/bofg_check.sv
verif/tb_battery_overvoltage_flip_guard.sv
